// ----- rtl/ldti_pkg.sv -----
// ----------------------------------------------------------------------------
// ldti_pkg - shared types and constants of the log-domain table interpolator
// Table entry layout, fixed-point constants and widths used across the block.
// ----------------------------------------------------------------------------
package ldti_pkg;

  // default number of table slots
  localparam int DEF_TABLE_DEPTH = 256;
  // fraction bits of the log-domain depth value
  localparam int FRAC_BITS = 48;
  // width of the entry count register and of the scan counter
  localparam int CNT_W = 9;
  // width of the divider numerator and of its step counter
  localparam int DIV_NUM_W = 96;
  localparam int DIV_STEP_W = 7;

  // reflectivity of 1.0 in UQ1.31
  localparam logic [31:0] ONE_R = 32'h8000_0000;
  // ln(2) in Q0.64
  localparam logic [63:0] LN2_Q64 = 64'hB172_17F7_D1CF_79AB;

  // one table entry: abscissa UQ8.24 and reflectivity UQ1.31
  typedef struct packed {
    logic [31:0] q;
    logic [31:0] r;
  } entry_t;

endpackage

// ----- rtl/ldti_table.sv -----
// ----------------------------------------------------------------------------
// ldti_table - abscissa and reflectivity storage
// One write port and one registered read port over a memory of entries.
// ----------------------------------------------------------------------------
module ldti_table #(
  parameter int DEPTH = ldti_pkg::DEF_TABLE_DEPTH,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic            clk,
  input  logic            wr_en,
  input  logic [AW-1:0]   wr_addr,
  input  logic [31:0]     wr_q,
  input  logic [31:0]     wr_r,
  input  logic [AW-1:0]   rd_addr,
  output ldti_pkg::entry_t rd_data
);
  import ldti_pkg::*;

  entry_t mem [DEPTH];
  entry_t wr_entry;

  // clamp reflectivity at 1.0 on the way in
  always_comb begin
    wr_entry.q = wr_q;
    wr_entry.r = (wr_r > ONE_R) ? ONE_R : wr_r;
  end

  // write one entry
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_entry;
    end
  end

  // registered read
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

// ----- rtl/ldti_mul.sv -----
// ----------------------------------------------------------------------------
// ldti_mul - shared 64x64 multiplier
// Forms the full 128-bit product from four 32x32 partial products, one per
// cycle, summed in an accumulator. Pulses done with the product ready.
// ----------------------------------------------------------------------------
module ldti_mul (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [63:0]  a,
  input  logic [63:0]  b,
  output logic         done,
  output logic [127:0] prod
);
  import ldti_pkg::*;

  localparam logic [2:0] LAST_PHASE = 3'd4;

  logic [63:0]  a_r;
  logic [63:0]  b_r;
  logic [63:0]  p_r;
  logic [1:0]   psel;
  logic [1:0]   psel_next;
  logic [2:0]   phase;
  logic         busy;
  logic [31:0]  op_a;
  logic [31:0]  op_b;
  logic [127:0] addend;

  // pick the partial product for this phase
  always_comb begin
    case (phase[1:0])
      2'd0: begin
        op_a = a_r[31:0];  op_b = b_r[31:0];  psel_next = 2'd0;
      end
      2'd1: begin
        op_a = a_r[31:0];  op_b = b_r[63:32]; psel_next = 2'd1;
      end
      2'd2: begin
        op_a = a_r[63:32]; op_b = b_r[31:0];  psel_next = 2'd1;
      end
      default: begin
        op_a = a_r[63:32]; op_b = b_r[63:32]; psel_next = 2'd2;
      end
    endcase
  end

  // align the registered partial product
  always_comb begin
    case (psel)
      2'd0:    addend = {64'b0, p_r};
      2'd1:    addend = {32'b0, p_r, 32'b0};
      default: addend = {p_r, 64'b0};
    endcase
  end

  // sequence the phases
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      phase <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        phase <= '0;
      end else if (busy) begin
        if (phase == LAST_PHASE) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          phase <= phase + 3'd1;
        end
      end
    end
  end

  // multiply and accumulate
  always_ff @(posedge clk) begin
    if (start) begin
      a_r  <= a;
      b_r  <= b;
      prod <= '0;
    end else if (busy) begin
      if (phase != LAST_PHASE) begin
        p_r  <= 64'(op_a) * 64'(op_b);
        psel <= psel_next;
      end
      if (phase != 3'd0) begin
        prod <= prod + addend;
      end
    end
  end

endmodule

// ----- rtl/ldti_div.sv -----
// ----------------------------------------------------------------------------
// ldti_div - shared restoring divider
// Divides a left-aligned numerator by a 32-bit divisor one bit per cycle.
// Keeps the low 64 quotient bits and flags any higher bit that was set.
// ----------------------------------------------------------------------------
module ldti_div (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic [ldti_pkg::DIV_NUM_W-1:0]     num,
  input  logic [ldti_pkg::DIV_STEP_W-1:0]    steps,
  input  logic [31:0]                        den,
  output logic                               done,
  output logic [63:0]                        quo,
  output logic                               ovf
);
  import ldti_pkg::*;

  logic [DIV_NUM_W-1:0]  num_r;
  logic [31:0]           den_r;
  logic [31:0]           rem;
  logic [DIV_STEP_W-1:0] cnt;
  logic                  busy;
  logic [32:0]           trial;
  logic                  qbit;
  logic [31:0]           rem_next;

  // one restoring step
  always_comb begin
    trial    = {rem, num_r[DIV_NUM_W-1]};
    qbit     = (trial >= {1'b0, den_r});
    rem_next = qbit ? 32'(trial - {1'b0, den_r}) : trial[31:0];
  end

  // count the steps
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= steps;
      end else if (busy) begin
        cnt <= cnt - DIV_STEP_W'(1);
        if (cnt == DIV_STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // shift numerator, update remainder and quotient
  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= num;
      den_r <= den;
      rem   <= '0;
      quo   <= '0;
      ovf   <= 1'b0;
    end else if (busy) begin
      num_r <= num_r << 1;
      rem   <= rem_next;
      quo   <= {quo[62:0], qbit};
      ovf   <= ovf | quo[63];
    end
  end

endmodule

// ----- rtl/log_domain_table_interpolator_unit.sv -----
// ----------------------------------------------------------------------------
// log_domain_table_interpolator_unit - reflectivity table lookup
// Scans a table of abscissas, interpolates linearly in log2 of reflectivity
// and exponentiates, using one shared multiplier and one shared divider.
// ----------------------------------------------------------------------------
// Usage:
//   s_* channel takes requests. s_tuser = op (0 writes an entry, 1 looks up).
//   s_tdata = {r_value, q_value, entry_index}. A write returns nothing; a
//   lookup returns one result on m_* with m_tdata = reflectivity (UQ1.31)
//   and m_tuser = status (1 = out of range).
//   cfg_* writes entries_in_use; it is always ready. The user must see that
//   it is written only while the block is idle; the block does not enforce it.
//   A lookup scans the table entries, then uses the shared multiplier for
//   48 squarings for each of the two log depths, then runs an 85-step
//   bit-serial division and up to about 20 series terms (each a multiplier
//   pass plus a division by the term index). Short cases (equal
//   abscissas, zero reflectivity, out of range) finish right after the scan.
//   One item is in flight at a time.
//   A finished result sits in the output register; while it waits, the next
//   request is accepted, and a second result holds the block until taken.
//   Reset clears the entry count and all control; table contents are
//   undefined until written.
// ----------------------------------------------------------------------------
module log_domain_table_interpolator_unit #(
  parameter int TABLE_DEPTH = ldti_pkg::DEF_TABLE_DEPTH
) (
  input  logic                       clk,
  input  logic                       rst,
  // request: entry_index [7:0], q_value [39:8], r_value [71:40]
  input  logic [71:0]                s_tdata,
  // request: op [0]
  input  logic                       s_tuser,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  // result: reflectivity [31:0]
  output logic [31:0]                m_tdata,
  // result: status [0]
  output logic                       m_tuser,
  output logic                       m_tvalid,
  input  logic                       m_tready,
  // entries_in_use write
  input  logic [ldti_pkg::CNT_W-1:0] cfg_data,
  input  logic                       cfg_valid,
  output logic                       cfg_ready
);
  import ldti_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_PREV    = 4'd1;
  localparam logic [3:0] S_SCAN    = 4'd2;
  localparam logic [3:0] S_SEG     = 4'd3;
  localparam logic [3:0] S_LG_INIT = 4'd4;
  localparam logic [3:0] S_LG_MUL  = 4'd5;
  localparam logic [3:0] S_PROD    = 4'd6;
  localparam logic [3:0] S_PROD_W  = 4'd7;
  localparam logic [3:0] S_DIV_W   = 4'd8;
  localparam logic [3:0] S_EXP     = 4'd9;
  localparam logic [3:0] S_Z_W     = 4'd10;
  localparam logic [3:0] S_T_CHK   = 4'd11;
  localparam logic [3:0] S_T_MUL   = 4'd12;
  localparam logic [3:0] S_T_DIV   = 4'd13;
  localparam logic [3:0] S_RND     = 4'd14;
  localparam logic [3:0] S_FIN     = 4'd15;

  localparam logic [5:0]           LAST_SQ   = 6'd47;
  localparam logic [6:0]           TERM_END  = 7'd64;
  localparam logic [56:0]          MAG_CAP   = {1'b1, 56'b0};
  localparam logic [DIV_STEP_W-1:0] PROD_STEPS = DIV_STEP_W'(85);
  localparam logic [DIV_STEP_W-1:0] TERM_STEPS = DIV_STEP_W'(64);

  logic [3:0]           state;
  logic [CNT_W-1:0]     entries;
  logic [CNT_W-1:0]     cnt_r;
  logic [CNT_W-1:0]     cnt_in;
  logic [CNT_W-1:0]     j;
  logic [CNT_W-1:0]     rd_ptr;
  logic [31:0]          q_r;
  entry_t               prev;
  entry_t               segb;
  entry_t               rd_data;
  logic                 lg_sel;
  logic [FRAC_BITS-1:0] f;
  logic [5:0]           it;
  logic [4:0]           kz;
  logic [52:0]          da;
  logic [52:0]          dn;
  logic                 neg;
  logic [31:0]          den;
  logic [58:0]          dd;
  logic [4:0]           ip;
  logic [63:0]          sum;
  logic [63:0]          term;
  logic [63:0]          z;
  logic [6:0]           kk;
  logic [31:0]          res;
  logic                 stat;

  logic                 wr_en;
  logic                 in_go;
  logic                 mul_start;
  logic [63:0]          mul_a;
  logic [63:0]          mul_b;
  logic                 mul_done;
  logic [127:0]         mul_prod;
  logic                 div_start;
  logic [DIV_NUM_W-1:0] div_num;
  logic [DIV_STEP_W-1:0] div_steps;
  logic [31:0]          div_den;
  logic                 div_done;
  logic [63:0]          div_quo;
  logic                 div_ovf;

  logic [31:0]          lg_x;
  logic [4:0]           lg_k;
  logic [63:0]          m_init;
  logic [63:0]          sq;
  logic [63:0]          m_new;
  logic [FRAC_BITS-1:0] f_new;
  logic [52:0]          d_new;
  logic [53:0]          d_diff;
  logic [32:0]          dq;
  logic [32:0]          dnq;
  logic [53:0]          d_abs;
  logic [32:0]          dq_abs;
  logic [32:0]          dnq_abs;
  logic [56:0]          mag;
  logic [58:0]          dd_next;
  logic [47:0]          gfrac;
  logic [5:0]           rshift;
  logic [63:0]          rnd_sum;
  logic [63:0]          rnd;

  // leading one position of a nonzero reflectivity
  function automatic logic [4:0] msb_pos(input logic [31:0] x);
    logic [4:0] k;
    k = '0;
    for (int i = 0; i < 32; i++) begin
      if (x[i]) k = 5'(i);
    end
    return k;
  endfunction

  assign s_tready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign in_go     = s_tvalid && s_tready;
  assign wr_en     = in_go && !s_tuser && (int'(s_tdata[7:0]) < TABLE_DEPTH);
  assign cnt_in    = (int'(entries) > TABLE_DEPTH) ? CNT_W'(TABLE_DEPTH) : entries;

  // read pointer for the scan
  always_comb begin
    case (state)
      S_PREV:  rd_ptr = CNT_W'(1);
      S_SCAN:  rd_ptr = j + CNT_W'(1);
      default: rd_ptr = '0;
    endcase
  end

  // log depth datapath
  always_comb begin
    lg_x   = lg_sel ? segb.r : prev.r;
    lg_k   = msb_pos(lg_x);
    m_init = 64'(lg_x) << (6'd62 - {1'b0, lg_k});
    sq     = mul_prod[125:62];
    m_new  = sq[63] ? (sq >> 1) : sq;
    f_new  = {f[FRAC_BITS-2:0], sq[63]};
    d_new  = {kz, 48'b0} - {5'b0, f_new};
  end

  // interpolation datapath
  always_comb begin
    d_diff  = {1'b0, dn} - {1'b0, da};
    dq      = {1'b0, q_r} - {1'b0, prev.q};
    dnq     = {1'b0, segb.q} - {1'b0, prev.q};
    d_abs   = d_diff[53] ? (54'd0 - d_diff) : d_diff;
    dq_abs  = dq[32] ? (33'd0 - dq) : dq;
    dnq_abs = dnq[32] ? (33'd0 - dnq) : dnq;
    mag     = (div_ovf || (div_quo[63:56] != 8'd0)) ? MAG_CAP : {1'b0, div_quo[55:0]};
    dd_next = neg ? (59'(da) - 59'(mag)) : (59'(da) + 59'(mag));
    gfrac   = 48'(49'h1_0000_0000_0000 - {1'b0, dd[47:0]});
  end

  // final rounding shift
  always_comb begin
    rshift  = 6'd32 + {1'b0, ip};
    rnd_sum = sum + (64'd1 << (rshift - 6'd1));
    rnd     = rnd_sum >> rshift;
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      entries   <= '0;
      m_tvalid  <= 1'b0;
      mul_start <= 1'b0;
      div_start <= 1'b0;
    end else begin
      mul_start <= 1'b0;
      div_start <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        entries <= cfg_data;
      end
      // drop a taken result unless a new one is loaded this cycle
      if (m_tvalid && m_tready && (state != S_FIN)) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_go && s_tuser) begin
            q_r   <= s_tdata[39:8];
            cnt_r <= cnt_in;
            if (cnt_in < CNT_W'(2)) begin
              res   <= '0;
              stat  <= 1'b1;
              state <= S_FIN;
            end else begin
              state <= S_PREV;
            end
          end
        end
        S_PREV: begin
          prev  <= rd_data;
          j     <= CNT_W'(1);
          state <= S_SCAN;
        end
        S_SCAN: begin
          if (rd_data.q < q_r) begin
            prev <= rd_data;
            if (j + CNT_W'(1) < cnt_r) begin
              j <= j + CNT_W'(1);
            end else begin
              res   <= '0;
              stat  <= 1'b1;
              state <= S_FIN;
            end
          end else begin
            segb  <= rd_data;
            state <= S_SEG;
          end
        end
        S_SEG: begin
          stat <= 1'b0;
          if (prev.q == segb.q) begin
            res   <= segb.r;
            state <= S_FIN;
          end else if ((prev.r == 32'd0) || (segb.r == 32'd0)) begin
            res   <= '0;
            state <= S_FIN;
          end else begin
            lg_sel <= 1'b0;
            state  <= S_LG_INIT;
          end
        end
        S_LG_INIT: begin
          kz        <= 5'd31 - lg_k;
          f         <= '0;
          it        <= '0;
          mul_a     <= m_init;
          mul_b     <= m_init;
          mul_start <= 1'b1;
          state     <= S_LG_MUL;
        end
        S_LG_MUL: begin
          if (mul_done) begin
            f <= f_new;
            if (it == LAST_SQ) begin
              if (lg_sel) begin
                dn    <= d_new;
                state <= S_PROD;
              end else begin
                da     <= d_new;
                lg_sel <= 1'b1;
                state  <= S_LG_INIT;
              end
            end else begin
              it        <= it + 6'd1;
              mul_a     <= m_new;
              mul_b     <= m_new;
              mul_start <= 1'b1;
            end
          end
        end
        S_PROD: begin
          if ((d_diff == 54'd0) || (dq == 33'd0)) begin
            dd    <= 59'(da);
            state <= S_EXP;
          end else begin
            neg       <= d_diff[53] ^ dq[32] ^ dnq[32];
            den       <= dnq_abs[31:0];
            mul_a     <= 64'(d_abs[52:0]);
            mul_b     <= 64'(dq_abs[31:0]);
            mul_start <= 1'b1;
            state     <= S_PROD_W;
          end
        end
        S_PROD_W: begin
          if (mul_done) begin
            div_num   <= {mul_prod[84:0], 11'b0};
            div_steps <= PROD_STEPS;
            div_den   <= den;
            div_start <= 1'b1;
            state     <= S_DIV_W;
          end
        end
        S_DIV_W: begin
          if (div_done) begin
            dd    <= dd_next;
            state <= S_EXP;
          end
        end
        S_EXP: begin
          if (dd[58] || (dd == 59'd0)) begin
            res   <= ONE_R;
            state <= S_FIN;
          end else if (dd[57:53] != 5'd0) begin
            res   <= '0;
            state <= S_FIN;
          end else begin
            ip <= dd[52:48];
            if (dd[47:0] == 48'd0) begin
              sum   <= {1'b1, 63'b0};
              state <= S_RND;
            end else begin
              mul_a     <= {gfrac, 16'b0};
              mul_b     <= LN2_Q64;
              mul_start <= 1'b1;
              state     <= S_Z_W;
            end
          end
        end
        S_Z_W: begin
          if (mul_done) begin
            z     <= mul_prod[127:64];
            term  <= mul_prod[127:64];
            sum   <= {2'b01, 62'b0};
            kk    <= 7'd2;
            state <= S_T_CHK;
          end
        end
        S_T_CHK: begin
          if ((term != 64'd0) && (kk < TERM_END)) begin
            sum       <= sum + (term >> 2);
            mul_a     <= term;
            mul_b     <= z;
            mul_start <= 1'b1;
            state     <= S_T_MUL;
          end else begin
            state <= S_RND;
          end
        end
        S_T_MUL: begin
          if (mul_done) begin
            div_num   <= {mul_prod[127:64], 32'b0};
            div_steps <= TERM_STEPS;
            div_den   <= 32'(kk);
            div_start <= 1'b1;
            state     <= S_T_DIV;
          end
        end
        S_T_DIV: begin
          if (div_done) begin
            term  <= div_quo;
            kk    <= kk + 7'd1;
            state <= S_T_CHK;
          end
        end
        S_RND: begin
          res   <= (rnd > 64'(ONE_R)) ? ONE_R : rnd[31:0];
          state <= S_FIN;
        end
        S_FIN: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= res;
            m_tuser  <= stat;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  ldti_table #(
    .DEPTH (TABLE_DEPTH),
    .AW    (AW)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (AW'(s_tdata[7:0])),
    .wr_q    (s_tdata[39:8]),
    .wr_r    (s_tdata[71:40]),
    .rd_addr (AW'(rd_ptr)),
    .rd_data (rd_data)
  );

  ldti_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  ldti_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .steps (div_steps),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo),
    .ovf   (div_ovf)
  );

  // out-of-range results carry zero reflectivity
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata == 32'd0)
    else $error("out-of-range result with nonzero reflectivity");

  // results never exceed 1.0
  a_res_cap: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata <= ONE_R)
    else $error("reflectivity above 1.0");

  // scan pointer stays inside the table in use
  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_SCAN |-> j < cnt_r)
    else $error("scan beyond entries in use");

  // a table write raises no result
  a_write_silent: assert property (@(posedge clk) disable iff (rst)
    in_go && !s_tuser && !m_tvalid |=> !m_tvalid)
    else $error("result after table write");

endmodule
